// ===== src/resp_tok_pkg.sv =====
package resp_tok_pkg;

    // Parse limits
    localparam int MAX_ELEMENTS  = 1024;
    localparam int MAX_TOKEN_LEN = 65535;
    localparam int ELEM_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
    localparam int NUM_MAX       = (MAX_ELEMENTS > MAX_TOKEN_LEN) ? MAX_ELEMENTS : MAX_TOKEN_LEN;
    // The accumulator saturates one above the larger limit: any larger value is an error
    localparam int NUM_CAP       = NUM_MAX + 1;
    localparam int NUM_W         = $clog2(NUM_CAP + 1);
    localparam int TOK_W         = 10;
    localparam int MAX_RES       = 3;

    // Result kinds
    localparam logic [1:0] K_BYTE = 2'd0;
    localparam logic [1:0] K_END  = 2'd1;
    localparam logic [1:0] K_OK   = 2'd2;
    localparam logic [1:0] K_ERR  = 2'd3;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_command;
    } t_cmd_word;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       token_byte;
        logic [TOK_W-1:0] token_number;
        logic             last_of_run;
    } t_res_word;

    // Results caused by one input word, item 0 first
    typedef struct packed {
        logic [1:0]                  count;
        t_res_word [MAX_RES-1:0]     items;
    } t_res_bundle;

endpackage

// ===== src/resp_tok_core.sv =====
module resp_tok_core
    import resp_tok_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_cmd_word   i_word,
    output t_res_bundle o_bundle
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SPLIT = 3'd1;
    localparam logic [2:0] PH_COUNT = 3'd2;
    localparam logic [2:0] PH_ELEM  = 3'd3;
    localparam logic [2:0] PH_LEN   = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_TCR   = 3'd6;
    localparam logic [2:0] PH_TLF   = 3'd7;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Number text progress: stage 0 leading space, 1 sign seen, 2 digits, 3 digits ended
    typedef struct packed {
        logic [1:0]       stage;
        logic             neg;
        logic [NUM_W-1:0] acc;
        logic             err;
    } t_num;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic t_num num_char(input t_num s, input logic [7:0] c);
        t_num             r;
        logic             dig;
        logic [NUM_W+3:0] v;
        r     = s;
        r.err = 1'b0;
        dig   = (c >= CH_ZERO) && (c <= CH_NINE);
        v     = (NUM_W+4)'(s.acc) * (NUM_W+4)'(10) + (NUM_W+4)'(c[3:0]);
        case (s.stage)
            2'd0: begin
                if (is_space(c)) begin
                    r = s;
                end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                    r.stage = 2'd1;
                    r.neg   = (c == CH_MINUS);
                end else if (dig) begin
                    r.stage = 2'd2;
                    r.acc   = NUM_W'(c[3:0]);
                end else begin
                    r.err = 1'b1;
                end
            end
            2'd1: begin
                if (dig) begin
                    r.stage = 2'd2;
                    r.acc   = NUM_W'(c[3:0]);
                end else begin
                    r.err = 1'b1;
                end
            end
            2'd2: begin
                if (dig) begin
                    r.acc = (v > (NUM_W+4)'(NUM_CAP)) ? NUM_W'(NUM_CAP) : v[NUM_W-1:0];
                end else begin
                    r.stage = 2'd3;
                end
            end
            default: r = s;
        endcase
        return r;
    endfunction

    function automatic t_res_word mk_res(input logic [1:0] k, input logic [7:0] b,
                                         input logic [TOK_W-1:0] n);
        t_res_word r;
        r.kind         = k;
        r.token_byte   = b;
        r.token_number = n;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    logic              r_framed, n_framed;
    logic              r_first, n_first;
    logic [2:0]        r_phase, n_phase;
    logic [NUM_W-1:0]  r_acc, n_acc;
    logic [1:0]        r_stage, n_stage;
    logic              r_neg, n_neg;
    logic [ELEM_W-1:0] r_elem, n_elem;
    logic [LEN_W-1:0]  r_left, n_left;
    logic              r_scr, n_scr;
    logic              r_open, n_open;
    logic [TOK_W-1:0]  r_tok, n_tok;
    logic              r_err, n_err;
    logic              r_stop, n_stop;

    logic [7:0]               c;
    logic                     do_split;
    logic                     do_framed;
    logic                     go2;
    logic                     ok;
    t_num                     cur;
    t_num                     t1;
    t_num                     t2;
    logic [1:0]               nres;
    t_res_word [MAX_RES-1:0]  items;

    always_comb begin
        c         = i_word.byte_in;
        n_framed  = r_framed;
        n_first   = r_first;
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_stage   = r_stage;
        n_neg     = r_neg;
        n_elem    = r_elem;
        n_left    = r_left;
        n_scr     = r_scr;
        n_open    = r_open;
        n_tok     = r_tok;
        n_err     = r_err;
        n_stop    = r_stop;
        nres      = 2'd0;
        items     = '0;
        go2       = 1'b1;
        ok        = 1'b0;
        cur       = '{stage: r_stage, neg: r_neg, acc: r_acc, err: 1'b0};
        t1        = cur;
        t2        = cur;
        do_split  = r_first ? (c != CH_STAR) : !r_framed;
        do_framed = !r_first && r_framed;

        if (r_first) begin
            n_first = 1'b0;
            if (c == CH_STAR) begin
                n_framed = 1'b1;
                n_phase  = PH_COUNT;
                n_acc    = '0;
                n_stage  = 2'd0;
                n_neg    = 1'b0;
                n_scr    = 1'b0;
            end else begin
                n_phase = PH_SPLIT;
            end
        end

        // Whitespace-split mode
        if (do_split) begin
            if (is_space(c)) begin
                if (r_open) begin
                    items[nres] = mk_res(K_END, 8'd0, r_tok);
                    nres        = nres + 2'd1;
                    n_tok       = r_tok + TOK_W'(1);
                    n_open      = 1'b0;
                end
            end else begin
                n_open      = 1'b1;
                items[nres] = mk_res(K_BYTE, c, r_tok);
                nres        = nres + 2'd1;
            end
        end

        // Framed mode: ignore everything after an error or a stop
        if (do_framed && !r_err && !r_stop) begin
            unique case (r_phase)
                PH_COUNT, PH_LEN: begin
                    if (r_scr) begin
                        if (c == CH_LF) begin
                            go2 = 1'b0;
                            // Close the number
                            if (r_stage < 2'd2) begin
                                n_err = 1'b1;
                            end else if (r_phase == PH_COUNT) begin
                                if (r_neg || (r_acc == '0) ||
                                    (r_acc > NUM_W'(MAX_ELEMENTS))) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_elem  = ELEM_W'(r_acc);
                                    n_phase = PH_ELEM;
                                    n_acc   = '0;
                                    n_stage = 2'd0;
                                    n_neg   = 1'b0;
                                    n_scr   = 1'b0;
                                end
                            end else begin
                                if ((r_neg && (r_acc != '0)) ||
                                    (r_acc > NUM_W'(MAX_TOKEN_LEN))) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_left  = LEN_W'(r_acc);
                                    n_phase = (r_acc == '0) ? PH_TCR : PH_DATA;
                                    n_acc   = '0;
                                    n_stage = 2'd0;
                                    n_neg   = 1'b0;
                                    n_scr   = 1'b0;
                                end
                            end
                        end else begin
                            // A lone CR is part of the number text
                            t1 = num_char(cur, CH_CR);
                            if (t1.err) begin
                                n_err = 1'b1;
                                go2   = 1'b0;
                            end else begin
                                cur   = t1;
                                n_scr = 1'b0;
                            end
                        end
                    end
                    if (go2) begin
                        if (c == CH_CR) begin
                            n_scr = 1'b1;
                        end else begin
                            t2 = num_char(cur, c);
                            cur = t2;
                            if (t2.err) begin
                                n_err = 1'b1;
                            end
                        end
                        n_acc   = cur.acc;
                        n_stage = cur.stage;
                        n_neg   = cur.neg;
                    end
                end
                PH_ELEM: begin
                    if (c == CH_DOLLAR) begin
                        n_phase = PH_LEN;
                        n_acc   = '0;
                        n_stage = 2'd0;
                        n_neg   = 1'b0;
                        n_scr   = 1'b0;
                    end else begin
                        n_stop = 1'b1;
                    end
                end
                PH_DATA: begin
                    items[nres] = mk_res(K_BYTE, c, r_tok);
                    nres        = nres + 2'd1;
                    n_left      = r_left - LEN_W'(1);
                    if (n_left == '0) begin
                        n_phase = PH_TCR;
                    end
                end
                PH_TCR: begin
                    if (c == CH_CR) begin
                        n_phase = PH_TLF;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_TLF: begin
                    if (c != CH_LF) begin
                        n_err = 1'b1;
                    end else begin
                        items[nres] = mk_res(K_END, 8'd0, r_tok);
                        nres        = nres + 2'd1;
                        n_tok       = r_tok + TOK_W'(1);
                        n_elem      = r_elem - ELEM_W'(1);
                        if (n_elem == '0) begin
                            n_stop = 1'b1;
                        end else begin
                            n_phase = PH_ELEM;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // End of command: close any open token, add status, return to reset state
        if (i_word.end_of_command) begin
            if (!n_framed) begin
                if (n_open) begin
                    items[nres] = mk_res(K_END, 8'd0, n_tok);
                    nres        = nres + 2'd1;
                end
                ok = 1'b1;
            end else if (n_err) begin
                ok = 1'b0;
            end else begin
                ok = n_stop || (n_phase == PH_ELEM);
            end
            items[nres] = mk_res(ok ? K_OK : K_ERR, 8'd0, '0);
            nres        = nres + 2'd1;
            n_framed = 1'b0;
            n_first  = 1'b1;
            n_phase  = PH_IDLE;
            n_acc    = '0;
            n_stage  = 2'd0;
            n_neg    = 1'b0;
            n_elem   = '0;
            n_left   = '0;
            n_scr    = 1'b0;
            n_open   = 1'b0;
            n_tok    = '0;
            n_err    = 1'b0;
            n_stop   = 1'b0;
        end

        if (nres != 2'd0) begin
            items[nres - 2'd1].last_of_run = 1'b1;
        end
        o_bundle.count = nres;
        o_bundle.items = items;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_framed <= 1'b0;
            r_first  <= 1'b1;
            r_phase  <= PH_IDLE;
            r_acc    <= '0;
            r_stage  <= 2'd0;
            r_neg    <= 1'b0;
            r_elem   <= '0;
            r_left   <= '0;
            r_scr    <= 1'b0;
            r_open   <= 1'b0;
            r_tok    <= '0;
            r_err    <= 1'b0;
            r_stop   <= 1'b0;
        end else if (i_accept) begin
            r_framed <= n_framed;
            r_first  <= n_first;
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_stage  <= n_stage;
            r_neg    <= n_neg;
            r_elem   <= n_elem;
            r_left   <= n_left;
            r_scr    <= n_scr;
            r_open   <= n_open;
            r_tok    <= n_tok;
            r_err    <= n_err;
            r_stop   <= n_stop;
        end
    end

endmodule

// ===== src/resp_tok_outq.sv =====
module resp_tok_outq
    import resp_tok_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_res_bundle i_bundle,
    output logic        o_free,
    output logic        o_valid,
    input  logic        i_ready,
    output t_res_word   o_word
);

    t_res_word [MAX_RES-1:0] r_items;
    logic [1:0]              r_cnt, n_cnt;
    logic [1:0]              r_idx, n_idx;

    // Room for a new bundle once at most the last result is leaving now
    assign o_free  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_items[r_idx];

    always_comb begin
        n_cnt = r_cnt;
        n_idx = r_idx;
        if (o_valid && i_ready) begin
            n_cnt = r_cnt - 2'd1;
            n_idx = r_idx + 2'd1;
        end
        if (i_load && (i_bundle.count != 2'd0)) begin
            n_cnt = i_bundle.count;
            n_idx = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && (i_bundle.count != 2'd0)) begin
            r_items <= i_bundle.items;
        end
    end

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && (i_bundle.count != 2'd0)) |=> o_valid)
        else $error("loaded results not presented");

    a_no_early_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > 2'd1) |-> !o_free)
        else $error("queue reported free with results pending");

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.last_of_run) |-> (r_cnt == 2'd1))
        else $error("last_of_run shown before final result of word");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && (i_bundle.count != 2'd0)) |-> o_free)
        else $error("bundle loaded over pending results");

endmodule

// ===== src/resp_command_tokenizer_top.sv =====
// Latency: the first result of a word is presented the cycle after the word is accepted.
// Throughput: one word per cycle while each word yields at most one result and the
// output is ready; a word that yields two or three results holds the input until all
// but its last result have left, since the output port drains one result per cycle while ready.
// Reset: synchronous, active low; clears parser state and drops queued results.
module resp_command_tokenizer_top
    import resp_tok_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_cmd_word i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_res_word o_out_word
);

    // The parser updates its state in the same cycle a word is accepted and hands all
    // results of that word to the output queue as one bundle. Every word, even one that
    // causes no result, waits until the queue has room for a new bundle.
    logic        in_accept;
    logic        q_free;
    t_res_bundle bundle;

    assign o_in_ready = q_free;
    assign in_accept  = i_in_valid && q_free;

    resp_tok_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_word   (i_in_word),
        .o_bundle (bundle)
    );

    // Hold the results of one word and present them one result per handshake
    resp_tok_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_accept),
        .i_bundle (bundle),
        .o_free   (q_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_word   (o_out_word)
    );

endmodule

// ===== tb/tokenizer_checker.sv =====
module tokenizer_checker
    import resp_tok_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_cmd_word i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_res_word i_out_word,
    output int        o_fail_count,
    output int        o_pending
);

    localparam logic [7:0]  CH_STAR   = 8'h2A;
    localparam logic [7:0]  CH_DOLLAR = 8'h24;
    localparam logic [7:0]  CH_CR     = 8'h0D;
    localparam logic [7:0]  CH_LF     = 8'h0A;
    localparam logic [7:0]  CH_SPACE  = 8'h20;
    localparam logic [7:0]  CH_PLUS   = 8'h2B;
    localparam logic [7:0]  CH_MINUS  = 8'h2D;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_NINE   = 8'h39;
    localparam logic [31:0] NUM_SAT   = 32'h0200_0000;
    localparam int          SHOWN     = 10;

    typedef enum logic [2:0] {
        ST_IDLE, ST_WORDS, ST_COUNT, ST_ELEM, ST_LEN, ST_DATA, ST_TRAIL_CR, ST_TRAIL_LF
    } t_parse_st;

    typedef enum logic [1:0] {NS_LEAD, NS_SIGN, NS_DIGITS, NS_TAIL} t_num_st;

    // predicted parser state
    logic        framed;
    logic        at_first;
    t_parse_st   ph;
    logic [25:0] num_acc;
    t_num_st     num_st;
    logic        num_neg;
    logic [10:0] elems_left;
    logic [16:0] bytes_left;
    logic        cr_seen;
    logic        tok_open;
    logic [10:0] tok_count;
    logic        err_seen;
    logic        stopped;

    t_res_word   token_stream_q[$];
    int          made_now;
    int          bad_results = 0;
    int          pending_n   = 0;

    assign o_fail_count = bad_results;
    assign o_pending    = pending_n;

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    task automatic clear_number();
        num_acc = '0;
        num_st  = NS_LEAD;
        num_neg = 1'b0;
        cr_seen = 1'b0;
    endtask

    task automatic clear_parse();
        framed     = 1'b0;
        at_first   = 1'b1;
        ph         = ST_IDLE;
        clear_number();
        elems_left = '0;
        bytes_left = '0;
        tok_open   = 1'b0;
        tok_count  = '0;
        err_seen   = 1'b0;
        stopped    = 1'b0;
    endtask

    task automatic emit_result(input logic [1:0] k, input logic [7:0] b,
                               input logic [10:0] n);
        t_res_word r;
        r.kind         = k;
        r.token_byte   = b;
        r.token_number = n[TOK_W-1:0];
        r.last_of_run  = 1'b0;
        token_stream_q = {token_stream_q, r};
        made_now++;
    endtask

    task automatic number_char(input logic [7:0] c);
        logic [31:0] v;
        case (num_st)
            NS_LEAD: begin
                if (!is_blank(c)) begin
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        num_st  = NS_SIGN;
                        num_neg = (c == CH_MINUS);
                    end else if (is_digit(c)) begin
                        num_st  = NS_DIGITS;
                        num_acc = 26'(c - CH_ZERO);
                    end else begin
                        err_seen = 1'b1;
                    end
                end
            end
            NS_SIGN: begin
                if (is_digit(c)) begin
                    num_st  = NS_DIGITS;
                    num_acc = 26'(c - CH_ZERO);
                end else begin
                    err_seen = 1'b1;
                end
            end
            NS_DIGITS: begin
                if (is_digit(c)) begin
                    // saturate well above both limits
                    v       = 32'(num_acc) * 32'd10 + 32'(c - CH_ZERO);
                    num_acc = (v > NUM_SAT) ? NUM_SAT[25:0] : v[25:0];
                end else begin
                    num_st = NS_TAIL;
                end
            end
            default: ;
        endcase
    endtask

    task automatic number_done();
        if (num_st == NS_LEAD || num_st == NS_SIGN) begin
            err_seen = 1'b1;
        end else if (ph == ST_COUNT) begin
            if (num_neg || num_acc == 0 || num_acc > MAX_ELEMENTS) begin
                err_seen = 1'b1;
            end else begin
                elems_left = 11'(num_acc);
                ph         = ST_ELEM;
                clear_number();
            end
        end else begin
            // minus zero is a valid empty length
            if ((num_neg && num_acc != 0) || num_acc > MAX_TOKEN_LEN) begin
                err_seen = 1'b1;
            end else begin
                bytes_left = 17'(num_acc);
                ph         = (num_acc == 0) ? ST_TRAIL_CR : ST_DATA;
                clear_number();
            end
        end
    endtask

    task automatic number_byte(input logic [7:0] c);
        if (cr_seen) begin
            if (c == CH_LF) begin
                number_done();
                return;
            end
            // a lone CR belongs to the number text
            number_char(CH_CR);
            if (err_seen) return;
            cr_seen = 1'b0;
        end
        if (c == CH_CR) cr_seen = 1'b1;
        else number_char(c);
    endtask

    task automatic split_byte(input logic [7:0] c);
        if (is_blank(c)) begin
            if (tok_open) begin
                emit_result(K_END, 8'h00, tok_count);
                tok_count = tok_count + 11'd1;
                tok_open  = 1'b0;
            end
        end else begin
            tok_open = 1'b1;
            emit_result(K_BYTE, c, tok_count);
        end
    endtask

    task automatic framed_byte(input logic [7:0] c);
        if (err_seen || stopped) return;
        case (ph)
            ST_COUNT, ST_LEN: number_byte(c);
            ST_ELEM: begin
                if (c == CH_DOLLAR) begin
                    ph = ST_LEN;
                    clear_number();
                end else begin
                    stopped = 1'b1;
                end
            end
            ST_DATA: begin
                emit_result(K_BYTE, c, tok_count);
                bytes_left = bytes_left - 17'd1;
                if (bytes_left == 0) ph = ST_TRAIL_CR;
            end
            ST_TRAIL_CR: begin
                if (c == CH_CR) ph = ST_TRAIL_LF;
                else err_seen = 1'b1;
            end
            ST_TRAIL_LF: begin
                if (c != CH_LF) begin
                    err_seen = 1'b1;
                end else begin
                    emit_result(K_END, 8'h00, tok_count);
                    tok_count  = tok_count + 11'd1;
                    elems_left = elems_left - 11'd1;
                    if (elems_left == 0) stopped = 1'b1;
                    else ph = ST_ELEM;
                end
            end
            default: ;
        endcase
    endtask

    task automatic tokenize_word(input logic [7:0] c, input logic eoc);
        logic      ok;
        t_res_word tail;
        made_now = 0;
        if (at_first) begin
            at_first = 1'b0;
            if (c == CH_STAR) begin
                framed = 1'b1;
                ph     = ST_COUNT;
                clear_number();
            end else begin
                ph = ST_WORDS;
                split_byte(c);
            end
        end else if (framed) begin
            framed_byte(c);
        end else begin
            split_byte(c);
        end
        if (eoc) begin
            if (!framed) begin
                if (tok_open) emit_result(K_END, 8'h00, tok_count);
                ok = 1'b1;
            end else if (err_seen) begin
                ok = 1'b0;
            end else begin
                ok = stopped || ph == ST_ELEM;
            end
            emit_result(ok ? K_OK : K_ERR, 8'h00, 11'd0);
            clear_parse();
        end
        if (made_now > 0) begin
            tail = token_stream_q[token_stream_q.size() - 1];
            tail.last_of_run = 1'b1;
            token_stream_q[token_stream_q.size() - 1] = tail;
        end
    endtask

    always @(posedge i_clk) begin
        t_res_word want;
        if (!i_rst_n) begin
            clear_parse();
            token_stream_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (token_stream_q.size() == 0) begin
                    if (bad_results < SHOWN)
                        $display("unexpected result: kind=%0d byte=%02h tok=%0d last=%0b",
                                 i_out_word.kind, i_out_word.token_byte,
                                 i_out_word.token_number, i_out_word.last_of_run);
                    bad_results++;
                end else begin
                    want = token_stream_q.pop_front();
                    if (i_out_word.kind !== want.kind ||
                        i_out_word.token_byte !== want.token_byte ||
                        i_out_word.token_number !== want.token_number ||
                        i_out_word.last_of_run !== want.last_of_run) begin
                        if (bad_results < SHOWN)
                            $display("mismatch: expected %0d/%02h/%0d/%0b got %0d/%02h/%0d/%0b",
                                     want.kind, want.token_byte, want.token_number,
                                     want.last_of_run, i_out_word.kind,
                                     i_out_word.token_byte, i_out_word.token_number,
                                     i_out_word.last_of_run);
                        bad_results++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                tokenize_word(i_in_word.byte_in, i_in_word.end_of_command);
        end
        pending_n = token_stream_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import resp_tok_pkg::*;

    localparam int RANDOM_WORDS = 170;   // random part length, in accepted words
    localparam int QUIET_TAIL   = 60;    // final words sent with no idling at all
    localparam int HOLD_AT      = 40;    // words sent before the long output hold-off
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 10;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_cmd_word i_in_word   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_res_word o_out_word;

    int        bad_results;
    int        open_results;
    int        words_sent  = 0;
    int        stall_count = 0;
    int        random_goal;
    bit        calm        = 1'b0;
    bit        hold_done   = 1'b0;
    logic [7:0] cmd_q[$];
    logic [7:0] blank_set[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    resp_command_tokenizer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    tokenizer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_word   (o_out_word),
        .o_fail_count (bad_results),
        .o_pending    (open_results)
    );

    // Watchdog: end the run if no word moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random ready bursts, one long hold-off so the block backs up into
    // its input, and steady ready once the run enters its quiet tail.
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_done && words_sent >= HOLD_AT) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (calm) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Offer one word and hold it until accepted; maybe drop valid for a burst first.
    task automatic put_word(input logic [7:0] b, input logic eoc);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= '{byte_in: b, end_of_command: eoc};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic add_byte(input logic [7:0] b);
        cmd_q = {cmd_q, b};
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) cmd_q = {cmd_q, s[i]};
    endtask

    task automatic add_blank();
        cmd_q = {cmd_q, blank_set[$urandom_range(0, 5)]};
    endtask

    // Stream the built command, marking its last byte, then clear it.
    task automatic send_cmd();
        for (int i = 0; i < cmd_q.size(); i++) put_word(cmd_q[i], i == cmd_q.size() - 1);
        cmd_q.delete();
    endtask

    task automatic run_text(input string s);
        add_text(s);
        send_cmd();
    endtask

    function automatic logic [7:0] pick_tok_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D));
        return c;
    endfunction

    // Array header claims n_decl elements; n_real of them are actually present.
    task automatic build_framed(input int n_decl, input int n_real);
        int len;
        add_text($sformatf("*%0d\r\n", n_decl));
        for (int e = 0; e < n_real; e++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
            add_text($sformatf("$%0d\r\n", len));
            repeat (len) add_byte(8'($urandom_range(0, 255)));
            add_text("\r\n");
        end
    endtask

    task automatic build_words(input int n_tok);
        if ($urandom_range(0, 1)) add_blank();
        for (int t = 0; t < n_tok; t++) begin
            repeat ($urandom_range(1, 5)) add_byte(pick_tok_char());
            if (t < n_tok - 1 || $urandom_range(0, 1)) repeat ($urandom_range(1, 3)) add_blank();
        end
    endtask

    // Number text with optional padding, sign, odd magnitudes and trailing junk.
    function automatic string num_text();
        string s;
        s = "";
        repeat ($urandom_range(0, 2)) s = {s, " "};
        case ($urandom_range(0, 3))
            0:       s = {s, "+"};
            1:       s = {s, "-"};
            default: ;
        endcase
        case ($urandom_range(0, 5))
            0: ;
            1: s = {s, $sformatf("%0d", $urandom_range(0, 3))};
            2: s = {s, $sformatf("%0d", $urandom_range(0, 70000))};
            3: s = {s, $urandom_range(0, 1) ? "65535" : "65536"};
            4: s = {s, $urandom_range(0, 1) ? "1024" : "1025"};
            default: s = {s, "123456789012"};
        endcase
        case ($urandom_range(0, 3))
            0:       s = {s, "x"};
            1:       s = {s, "\r7"};
            default: ;
        endcase
        return s;
    endfunction

    task automatic corrupt_cmd();
        int n;
        case ($urandom_range(0, 2))
            0: cmd_q[$urandom_range(1, cmd_q.size() - 1)] = 8'($urandom_range(0, 255));
            1: begin
                // truncate anywhere after the first byte
                n = $urandom_range(1, cmd_q.size() - 1);
                while (cmd_q.size() > n) void'(cmd_q.pop_back());
            end
            default: repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    initial begin
        int pick;
        int n_el;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single bytes at the extremes and in both modes.
        run_text("*");
        run_text("a");
        add_byte(8'h00); send_cmd();
        add_byte(8'hFF); send_cmd();
        run_text(" ");
        add_text("ab"); add_byte(8'h0B); add_byte(8'h0C); add_text("cd\t\r\nef"); send_cmd();
        // Framed: empty element, then an early end with raw CR and extreme bytes in data.
        run_text("*1\r\n$0\r\n\r\n");
        add_text("*2\r\n$3\r\n"); add_byte(8'h00); add_byte(8'hFF); add_byte(8'h0D);
        add_text("\r\n"); send_cmd();
        // Bad counts, limits and the exact maximum count.
        run_text("*0\r\n");
        run_text("*-1\r\n");
        run_text("*1025\r\n");
        run_text("*1024\r\n");
        run_text("*\r\n");
        run_text("*+\r\n");
        run_text("*x\r\n");
        // Padding, plus sign, trailing text, lone CR in a number and minus-zero length.
        run_text("* +2x\r\n$-0\r\n\r\n$1\r5\r\nz\r\n");
        // Bad and saturating lengths.
        run_text("*1\r\n$-3\r\n");
        run_text("*1\r\n$65536\r\n");
        run_text("*1\r\n$99999999999\r\n");
        // Truncation in a number, in data, in a long declared length and in the trailer.
        run_text("*12");
        run_text("*1\r\n$3\r\nab");
        run_text("*1\r\n$65535\r\nab");
        run_text("*1\r\n$1\r\na\r");
        // Missing dollar, bad trailer bytes, and junk after the last element.
        run_text("*1\r\nX");
        run_text("*2\r\n$1\r\naXY");
        run_text("*1\r\n$1\r\na\rY");
        run_text("*1\r\n$2\r\nab\r\nEXTRA");

        // Random commands, mostly well-formed arrays with random content.
        random_goal = words_sent + RANDOM_WORDS;
        while (words_sent < random_goal) begin
            if (words_sent >= random_goal - QUIET_TAIL) calm = 1'b1;
            pick = $urandom_range(0, 99);
            n_el = $urandom_range(1, 4);
            if (pick < 50) begin
                if ($urandom_range(0, 3) == 0) build_framed(n_el + 1, n_el);
                else build_framed(n_el, n_el);
                if ($urandom_range(0, 5) == 0) add_text("$");
            end else if (pick < 65) begin
                build_framed(n_el, n_el);
                corrupt_cmd();
            end else if (pick < 77) begin
                add_text({"*", num_text(), "\r\n"});
                if ($urandom_range(0, 1)) begin
                    add_text({"$", num_text(), "\r\n"});
                    repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 1)) add_text("\r\n");
                end
            end else begin
                build_words($urandom_range(1, 6));
            end
            send_cmd();
        end
        i_in_valid <= 1'b0;

        // Drain: wait for every predicted result, then keep watching for strays.
        @(posedge i_clk);
        while (open_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_results == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/resp_tok_pkg.sv
src/resp_tok_core.sv
src/resp_tok_outq.sv
src/resp_command_tokenizer_top.sv
tb/tokenizer_checker.sv
tb/testbench.sv
